@@ rtl/core/lesf_pkg.sv @@
package lesf_pkg;

    // Grid limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Field and state widths
    localparam int COL_W  = 10;
    localparam int ROW_W  = 10;
    localparam int SIZE_W = 11;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 1;

    typedef logic [COL_W-1:0]  t_col;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [CFG_W-1:0]  t_cfg;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // Zero reads as one, anything above the limit saturates
    function automatic t_cfg clamp_dim(input t_cfg v, input t_cfg maxv);
        t_cfg res;
        if (v == '0) begin
            res = t_cfg'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

@@ rtl/core/lesf_in_if.sv @@
interface lesf_in_if;
    logic valid;
    logic ready;
    logic is_obstacle;

    modport source (output valid, output is_obstacle, input ready);
    modport sink   (input valid, input is_obstacle, output ready);
endinterface

@@ rtl/core/lesf_out_if.sv @@
interface lesf_out_if;
    logic                   valid;
    logic                   ready;
    logic [lesf_pkg::COL_W-1:0]  top_left_col;
    logic [lesf_pkg::ROW_W-1:0]  top_left_row;
    logic [lesf_pkg::SIZE_W-1:0] side;

    modport source (output valid, output top_left_col, output top_left_row,
                    output side, input ready);
    modport sink   (input valid, input top_left_col, input top_left_row,
                    input side, output ready);
endinterface

@@ rtl/core/lesf_ram.sv @@
module lesf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port (old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/largest_empty_square_finder.sv @@
// Streams a binary grid in, one cell per transaction in row-major order, and
// after the grid's last cell delivers one transaction with the top-left column,
// top-left row and side of the largest all-empty square (side 0 when every cell
// is an obstacle; ties go to the square whose corner comes first in scan order).
// Grid size comes from grid_width (index 0) and grid_height (index 1); zero is
// taken as 1 and values above 1024 as 1024, and a write restarts the grid.
// Throughput is one cell per clock. The previous row's square size is first read
// from the line memory into a register, then stage 1 does the min-of-three
// update, write-back and best-square compare. Input stalls only when a
// finished result is still held in the output register and a second grid's
// last cell is ready to complete.
module largest_empty_square_finder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lesf_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [lesf_pkg::CFG_W-1:0] i_cfg_data,
    lesf_in_if.sink                    s_in,
    lesf_out_if.source                 m_out
);
    import lesf_pkg::*;

    localparam t_cfg MAX_W_CFG = t_cfg'(MAX_WIDTH);
    localparam t_cfg MAX_H_CFG = t_cfg'(MAX_HEIGHT);

    // Configuration
    t_cfg r_grid_width;
    t_cfg r_grid_height;
    t_cfg w_eff;
    t_cfg h_eff;

    // Stage 0: scan position
    t_col r_col;
    t_row r_row;
    logic accept;
    logic col_end;
    logic row_end;

    // Stage 1: square-size update
    logic  r_s1_valid;
    t_col  r_s1_col;
    t_row  r_s1_row;
    logic  r_s1_obs;
    logic  r_s1_last;
    logic  r_fwd_hit;
    t_size r_fwd_data;
    t_size r_left;
    t_size r_diag;
    t_size ram_rdata;
    t_size up_raw;
    t_size up;
    t_size left;
    t_size diag;
    t_size m;
    t_size s;
    t_row  tr;
    t_col  tc;
    logic  s1_stall;
    logic  s1_adv;

    // Best square
    t_size r_best_side;
    t_col  r_best_col;
    t_row  r_best_row;
    t_size n_best_side;
    t_col  n_best_col;
    t_row  n_best_row;

    // Output register
    logic  r_out_valid;
    t_col  r_out_col;
    t_row  r_out_row;
    t_size r_out_side;

    assign w_eff = clamp_dim(r_grid_width, MAX_W_CFG);
    assign h_eff = clamp_dim(r_grid_height, MAX_H_CFG);

    // Handshake: stall only when a finished grid cannot hand off its result
    assign s1_stall   = r_s1_valid && r_s1_last && r_out_valid && !m_out.ready;
    assign s1_adv     = r_s1_valid && !s1_stall;
    assign s_in.ready = !s1_stall;
    assign accept     = s_in.valid && !s1_stall;

    assign col_end = ({1'b0, r_col} + t_cfg'(1)) >= w_eff;
    assign row_end = ({1'b0, r_row} + t_cfg'(1)) >= h_eff;

    // Line memory: one square size per column of the previous row
    lesf_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (s),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Min-of-three recurrence; neighbors outside the grid are zero
    always_comb begin
        up_raw = r_fwd_hit ? r_fwd_data : ram_rdata;
        up     = (r_s1_row == '0) ? '0 : up_raw;
        left   = (r_s1_col == '0) ? '0 : r_left;
        diag   = (r_s1_row == '0 || r_s1_col == '0) ? '0 : r_diag;
        m      = up;
        if (left < m) begin
            m = left;
        end
        if (diag < m) begin
            m = diag;
        end
        s  = r_s1_obs ? '0 : m + t_size'(1);
        tr = t_row'({1'b0, r_s1_row} + t_size'(1) - s);
        tc = t_col'({1'b0, r_s1_col} + t_size'(1) - s);
    end

    // Best square, earliest top-left corner wins a tie
    always_comb begin
        n_best_side = r_best_side;
        n_best_col  = r_best_col;
        n_best_row  = r_best_row;
        if (s != '0 && (s > r_best_side ||
            (s == r_best_side &&
             (tr < r_best_row || (tr == r_best_row && tc < r_best_col))))) begin
            n_best_side = s;
            n_best_col  = tc;
            n_best_row  = tr;
        end
    end

    // Configuration and scan counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= t_cfg'(1);
            r_grid_height <= t_cfg'(1);
            r_col         <= '0;
            r_row         <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default:         r_grid_width  <= r_grid_width;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (!col_end) begin
                r_col <= r_col + t_col'(1);
            end else begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + t_row'(1);
            end
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!s1_stall) begin
            r_s1_valid <= accept;
        end
    end

    // Stage 1 payload, with forwarding when the same column is written and read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
            r_s1_obs   <= s_in.is_obstacle;
            r_s1_last  <= col_end && row_end;
            r_fwd_hit  <= s1_adv && (r_s1_col == r_col);
            r_fwd_data <= s;
        end
        if (s1_adv) begin
            r_left <= s;
            r_diag <= up;
        end
    end

    // Running best, cleared at grid end and on a configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_best_side <= '0;
            r_best_col  <= '0;
            r_best_row  <= '0;
        end else if (s1_adv) begin
            if (r_s1_last) begin
                r_best_side <= '0;
                r_best_col  <= '0;
                r_best_row  <= '0;
            end else begin
                r_best_side <= n_best_side;
                r_best_col  <= n_best_col;
                r_best_row  <= n_best_row;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (m_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            r_out_col  <= n_best_col;
            r_out_row  <= n_best_row;
            r_out_side <= n_best_side;
        end
    end

    assign m_out.valid        = r_out_valid;
    assign m_out.top_left_col = r_out_col;
    assign m_out.top_left_row = r_out_row;
    assign m_out.side         = r_out_side;

endmodule
